// ===== rtl/hoe_pkg.sv =====
package hoe_pkg;

  // Default sizes handed to the top level.
  localparam int LEVEL_WIDTH_DEF  = 48;
  localparam int PERIOD_WIDTH_DEF = 20;

  // Configuration port and field geometry.
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 48;
  localparam int FIELD_W     = 48;
  localparam int GAIN_W      = 32;
  localparam int INIT_W      = 48;
  localparam int CFG_PERIOD_W = 20;

  // Register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_SELF_GAIN       = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CROSS_GAIN      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DECAY_RATE      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ACTIVATOR_DECAY = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_PERIOD_TICKS    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_PULSE_TICKS     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_PULSE_AMOUNT    = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_INITIAL_A       = 3'd7;

  // Register reset values.
  localparam logic [GAIN_W-1:0]       SELF_GAIN_RST  = 32'd2516582;
  localparam logic [GAIN_W-1:0]       CROSS_GAIN_RST = 32'd503316480;
  localparam logic [GAIN_W-1:0]       DECAY_RST      = 32'd1677722;
  localparam logic [GAIN_W-1:0]       ACT_DECAY_RST  = 32'd16777216;
  localparam logic [CFG_PERIOD_W-1:0] PERIOD_RST     = 20'd100000;
  localparam logic [CFG_PERIOD_W-1:0] PULSE_RST      = 20'd2500;
  localparam logic [GAIN_W-1:0]       PULSE_AMT_RST  = 32'd68719477;
  localparam logic [INIT_W-1:0]       INIT_A_RST     = 48'd51539607552;

  // Arithmetic constants: dt in Q0.32, 0.25 in Q.36, and the 1e-7 floor.
  localparam logic [63:0] DT_Q32    = 64'd42949673;
  localparam logic [63:0] QUARTER   = 64'h0000_0004_0000_0000;
  localparam logic [63:0] CUT_LIMIT = 64'd6872;

  // Multiplier and divider sequencing.
  localparam logic [2:0] MUL_LAST = 3'd4;
  localparam logic [5:0] DIV_LAST = 6'd36;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOAD, ST_PULSE,
    ST_H_SQ, ST_H_DEN, ST_H_UP, ST_H_DN,
    ST_T1, ST_T2, ST_T3, ST_T4, ST_T5, ST_T6,
    ST_K1, ST_K2, ST_E1, ST_E2, ST_E3,
    ST_FIN, ST_OUT, ST_MUL, ST_DIV
  } state_t;

  // Right shift applied to a finished product.
  typedef enum logic [2:0] {SH_0, SH_24, SH_32, SH_36, SH_56} shift_t;

  // Which level family the saturation pass is working on.
  typedef enum logic [1:0] {HK_SIGMA, HK_ANTI, HK_ACT} hill_kind_t;

endpackage

// ===== rtl/hill_ode_euler_stepper.sv =====
// Nine-level gene-circuit stepper. Each request is one time tick: optional
// restart, period wrap, activator pulse, then one forward-Euler step of the
// sigma, anti-sigma and activator levels, returning all nine levels. Each
// tick uses the single 32x32 multiplier (44 products), the single restoring
// divider (18 quotients, one bit per cycle) and the sequencer steps between
// them. The input is stalled while a tick is in progress; a finished result
// waits in the output register and a new request may be taken while it
// waits. Configuration writes take effect at once and should be issued only
// while the block is idle.
module hill_ode_euler_stepper #(
  parameter int LEVEL_WIDTH  = hoe_pkg::LEVEL_WIDTH_DEF,
  parameter int PERIOD_WIDTH = hoe_pkg::PERIOD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [hoe_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [hoe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_restart,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [hoe_pkg::FIELD_W-1:0]     out_level_a,
  output logic [hoe_pkg::FIELD_W-1:0]     out_level_b,
  output logic [hoe_pkg::FIELD_W-1:0]     out_level_c,
  output logic [hoe_pkg::FIELD_W-1:0]     out_anti_level_a,
  output logic [hoe_pkg::FIELD_W-1:0]     out_anti_level_b,
  output logic [hoe_pkg::FIELD_W-1:0]     out_anti_level_c,
  output logic [hoe_pkg::FIELD_W-1:0]     out_activator_a,
  output logic [hoe_pkg::FIELD_W-1:0]     out_activator_b,
  output logic [hoe_pkg::FIELD_W-1:0]     out_activator_c
);
  import hoe_pkg::*;

  localparam int          L    = LEVEL_WIDTH;
  localparam int          P    = PERIOD_WIDTH;
  localparam logic [63:0] LMAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - L);

  // Configuration registers.
  logic [GAIN_W-1:0] self_gain_r, cross_gain_r, decay_r, act_decay_r, pulse_amt_r;
  logic [P-1:0]      period_r, pulse_ticks_r;
  logic [INIT_W-1:0] init_a_r;

  // Model state.
  logic [L-1:0] sig_r [3], anti_r [3], act_r [3];
  logic [L-1:0] sig_nxt [3], anti_nxt [3], act_nxt [3];
  logic [P-1:0] pos_r, pos_nxt;
  logic [1:0]   gen_r, gen_nxt;

  // Sequencer.
  state_t     state_r, state_nxt, ret_r, ret_nxt;
  hill_kind_t hk_r, hk_nxt;
  logic [1:0] vi_r, vi_nxt;
  logic [3:0] ej_r, ej_nxt;
  logic       restart_r, restart_nxt;

  // Shared multiplier.
  logic [63:0]  opa_r, opa_nxt, opb_r, opb_nxt, prod_r, prod_nxt;
  shift_t       sh_r, sh_nxt;
  logic [2:0]   mcnt_r, mcnt_nxt, mprev;
  logic [1:0]   mslot;
  logic [127:0] acc_r, acc_nxt;
  logic [63:0]  mres;

  // Shared divider.
  logic [63:0] dr_r, dr_nxt, dden_r, dden_nxt, dshift;
  logic [36:0] dq_r, dq_nxt;
  logic [5:0]  dcnt_r, dcnt_nxt;
  logic        dtake;

  // Intermediate terms.
  logic [36:0] fs_r, fs_nxt, fa_r, fa_nxt, ga_r, ga_nxt;
  logic [63:0] drive_r [3], drive_nxt [3], self_r [3], self_nxt [3];
  logic [63:0] kdec_r, kdec_nxt, kact_r, kact_nxt, eup_r, eup_nxt;

  // Output register.
  logic           out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0] out_lv_r [9], out_lv_nxt [9];

  // Combinational helpers.
  logic [P-1:0]  period_eff;
  logic [P:0]    pos_inc;
  logic [64:0]   sum65;
  logic [63:0]   hx, den, x2, gain, prev, diff, ev, init_clamp;
  logic          load_out;

  assign period_eff = (period_r == '0) ? P'(1) : period_r;
  assign init_clamp = (64'(init_a_r) > LMAX) ? LMAX : 64'(init_a_r);
  assign load_out   = !out_valid_r || !out_stall;

  // Final shift of the accumulated product, saturating at all ones.
  always_comb begin
    case (sh_r)
      SH_0:    mres = (|acc_r[127:64])  ? '1 : acc_r[63:0];
      SH_24:   mres = (|acc_r[127:88])  ? '1 : acc_r[87:24];
      SH_32:   mres = (|acc_r[127:96])  ? '1 : acc_r[95:32];
      SH_36:   mres = (|acc_r[127:100]) ? '1 : acc_r[99:36];
      SH_56:   mres = (|acc_r[127:120]) ? '1 : acc_r[119:56];
      default: mres = '0;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_PULSE;
      ST_PULSE: state_nxt = ST_H_SQ;
      ST_H_SQ:  begin state_nxt = ST_MUL; ret_nxt = ST_H_DEN; end
      ST_H_DEN: begin state_nxt = ST_DIV; ret_nxt = ST_H_UP; end
      ST_H_UP:  begin state_nxt = ST_DIV; ret_nxt = ST_H_DN; end
      ST_H_DN:  state_nxt = (hk_r == HK_ACT) ? ST_T1 : ST_H_SQ;
      ST_T1:    begin state_nxt = ST_MUL; ret_nxt = ST_T2; end
      ST_T2:    begin state_nxt = ST_MUL; ret_nxt = ST_T3; end
      ST_T3:    begin state_nxt = ST_MUL; ret_nxt = ST_T4; end
      ST_T4:    begin state_nxt = ST_MUL; ret_nxt = ST_T5; end
      ST_T5:    begin state_nxt = ST_MUL; ret_nxt = ST_T6; end
      ST_T6:    state_nxt = (vi_r == 2'd2) ? ST_K1 : ST_H_SQ;
      ST_K1:    begin state_nxt = ST_MUL; ret_nxt = ST_K2; end
      ST_K2:    begin state_nxt = ST_MUL; ret_nxt = ST_E1; end
      ST_E1:    begin state_nxt = ST_MUL; ret_nxt = ST_E2; end
      ST_E2:    begin state_nxt = ST_MUL; ret_nxt = ST_E3; end
      ST_E3:    state_nxt = (ej_r == 4'd8) ? ST_FIN : ST_E1;
      ST_FIN:   state_nxt = ST_OUT;
      ST_OUT:   if (load_out) state_nxt = ST_IDLE;
      ST_MUL:   if (mcnt_r == MUL_LAST) state_nxt = ret_r;
      ST_DIV:   if (dcnt_r == DIV_LAST) state_nxt = ret_r;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and handshake outputs.
  always_comb begin
    in_stall    = (state_r != ST_IDLE);
    restart_nxt = restart_r;
    hk_nxt      = hk_r;
    vi_nxt      = vi_r;
    ej_nxt      = ej_r;
    pos_nxt     = pos_r;
    gen_nxt     = gen_r;
    for (int k = 0; k < 3; k++) begin
      sig_nxt[k]   = sig_r[k];
      anti_nxt[k]  = anti_r[k];
      act_nxt[k]   = act_r[k];
      drive_nxt[k] = drive_r[k];
      self_nxt[k]  = self_r[k];
    end
    opa_nxt  = opa_r;
    opb_nxt  = opb_r;
    sh_nxt   = sh_r;
    mcnt_nxt = mcnt_r;
    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    dr_nxt   = dr_r;
    dden_nxt = dden_r;
    dq_nxt   = dq_r;
    dcnt_nxt = dcnt_r;
    fs_nxt   = fs_r;
    fa_nxt   = fa_r;
    ga_nxt   = ga_r;
    kdec_nxt = kdec_r;
    kact_nxt = kact_r;
    eup_nxt  = eup_r;
    out_valid_nxt = out_valid_r && out_stall;
    for (int k = 0; k < 9; k++) out_lv_nxt[k] = out_lv_r[k];

    mprev   = mcnt_r - 3'd1;
    mslot   = {1'b0, mprev[0]} + {1'b0, mprev[1]};
    dshift  = {dr_r[62:0], 1'b0};
    dtake   = dr_r[63] || (dshift >= dden_r);
    pos_inc = {1'b0, pos_r} + (P+1)'(1);
    sum65   = '0;
    hx      = '0;
    den     = '0;
    x2      = '0;
    gain    = '0;
    prev    = '0;
    diff    = '0;
    ev      = '0;

    // Level under the saturation pass.
    case (hk_r)
      HK_SIGMA: hx = 64'(sig_r[vi_r]);
      HK_ANTI:  hx = 64'(anti_r[vi_r]);
      HK_ACT:   hx = 64'(act_r[vi_r]);
      default:  hx = '0;
    endcase

    // Previous level and drive term of the variable being stepped.
    case (ej_r)
      4'd0: begin prev = 64'(sig_r[0]); sum65 = {1'b0, self_r[0]} + {1'b0, drive_r[2]}; end
      4'd1: begin prev = 64'(sig_r[1]); sum65 = {1'b0, self_r[1]} + {1'b0, drive_r[0]}; end
      4'd2: begin prev = 64'(sig_r[2]); sum65 = {1'b0, self_r[2]} + {1'b0, drive_r[1]}; end
      4'd3: begin prev = 64'(anti_r[0]); sum65 = {1'b0, drive_r[0]}; end
      4'd4: begin prev = 64'(anti_r[1]); sum65 = {1'b0, drive_r[1]}; end
      4'd5: begin prev = 64'(anti_r[2]); sum65 = {1'b0, drive_r[2]}; end
      4'd6: prev = 64'(act_r[0]);
      4'd7: prev = 64'(act_r[1]);
      4'd8: prev = 64'(act_r[2]);
      default: prev = '0;
    endcase
    gain = sum65[64] ? '1 : sum65[63:0];

    case (state_r)
      ST_IDLE: begin
        if (in_valid) restart_nxt = in_restart;
      end

      // Restart load, then wrap a position that ran past the period.
      ST_LOAD: begin
        if (restart_r) begin
          for (int k = 0; k < 3; k++) begin
            sig_nxt[k]  = '0;
            anti_nxt[k] = '0;
            act_nxt[k]  = '0;
          end
          sig_nxt[0] = L'(init_clamp);
          pos_nxt    = '0;
          gen_nxt    = '0;
        end else if (pos_r >= period_eff) begin
          pos_nxt = '0;
          gen_nxt = (gen_r >= 2'd2) ? 2'd0 : gen_r + 2'd1;
        end
      end

      // Pulse into the current generation's activator near the period end.
      ST_PULSE: begin
        if ({1'b0, pos_r} + {1'b0, pulse_ticks_r} > {1'b0, period_eff} && gen_r != 2'd3) begin
          sum65 = {1'b0, 64'(act_r[gen_r])} + 65'(pulse_amt_r);
          act_nxt[gen_r] = (sum65 > 65'(LMAX)) ? L'(LMAX) : L'(sum65);
        end
        hk_nxt = HK_SIGMA;
        vi_nxt = 2'd0;
      end

      // Saturation terms: square, then up and down quotients.
      ST_H_SQ: begin
        opa_nxt = hx; opb_nxt = hx; sh_nxt = SH_36;
        mcnt_nxt = '0; acc_nxt = '0;
      end
      ST_H_DEN: begin
        sum65 = {1'b0, mres} + {1'b0, QUARTER};
        den   = sum65[64] ? '1 : sum65[63:0];
        x2    = (mres > den) ? den : mres;
        dr_nxt = x2; dden_nxt = den; dcnt_nxt = '0;
      end
      ST_H_UP: begin
        if (hk_r == HK_SIGMA) fs_nxt = dq_r;
        if (hk_r == HK_ACT)   fa_nxt = dq_r;
        dr_nxt = QUARTER; dcnt_nxt = '0;
      end
      ST_H_DN: begin
        if (hk_r == HK_ANTI)  ga_nxt = dq_r;
        case (hk_r)
          HK_SIGMA: hk_nxt = HK_ANTI;
          HK_ANTI:  hk_nxt = HK_ACT;
          default:  hk_nxt = HK_SIGMA;
        endcase
      end

      // Drive and self-activation products for one factor.
      ST_T1: begin
        opa_nxt = 64'(fs_r); opb_nxt = 64'(fa_r); sh_nxt = SH_36;
        mcnt_nxt = '0; acc_nxt = '0;
      end
      ST_T2: begin
        opa_nxt = mres; opb_nxt = 64'(ga_r); sh_nxt = SH_36;
        mcnt_nxt = '0; acc_nxt = '0;
      end
      ST_T3: begin
        opa_nxt = 64'(cross_gain_r); opb_nxt = mres; sh_nxt = SH_24;
        mcnt_nxt = '0; acc_nxt = '0;
      end
      ST_T4: begin
        drive_nxt[vi_r] = mres;
        opa_nxt = 64'(fs_r); opb_nxt = 64'(ga_r); sh_nxt = SH_36;
        mcnt_nxt = '0; acc_nxt = '0;
      end
      ST_T5: begin
        opa_nxt = 64'(self_gain_r); opb_nxt = mres; sh_nxt = SH_24;
        mcnt_nxt = '0; acc_nxt = '0;
      end
      ST_T6: begin
        self_nxt[vi_r] = mres;
        vi_nxt = (vi_r == 2'd2) ? 2'd0 : vi_r + 2'd1;
        hk_nxt = HK_SIGMA;
      end

      // Decay rates scaled by dt.
      ST_K1: begin
        opa_nxt = 64'(decay_r); opb_nxt = DT_Q32; sh_nxt = SH_0;
        mcnt_nxt = '0; acc_nxt = '0;
      end
      ST_K2: begin
        kdec_nxt = mres;
        opa_nxt = 64'(act_decay_r); opb_nxt = DT_Q32; sh_nxt = SH_0;
        mcnt_nxt = '0; acc_nxt = '0;
        ej_nxt = '0;
      end

      // Euler step of one variable: gain*dt, prev*rate*dt, then apply.
      ST_E1: begin
        if (ej_r == 4'd0) kact_nxt = mres;
        opa_nxt = gain; opb_nxt = DT_Q32; sh_nxt = SH_32;
        mcnt_nxt = '0; acc_nxt = '0;
      end
      ST_E2: begin
        eup_nxt = mres;
        opa_nxt = prev; opb_nxt = (ej_r < 4'd6) ? kdec_r : kact_r; sh_nxt = SH_56;
        mcnt_nxt = '0; acc_nxt = '0;
      end
      ST_E3: begin
        if (eup_r >= mres) begin
          sum65 = {1'b0, prev} + {1'b0, eup_r - mres};
          ev = (sum65 > 65'(LMAX)) ? LMAX : sum65[63:0];
        end else begin
          diff = mres - eup_r;
          ev = (prev > diff) ? prev - diff : '0;
        end
        if (ev < CUT_LIMIT) ev = '0;
        case (ej_r)
          4'd0: sig_nxt[0]  = L'(ev);
          4'd1: sig_nxt[1]  = L'(ev);
          4'd2: sig_nxt[2]  = L'(ev);
          4'd3: anti_nxt[0] = L'(ev);
          4'd4: anti_nxt[1] = L'(ev);
          4'd5: anti_nxt[2] = L'(ev);
          4'd6: act_nxt[0]  = L'(ev);
          4'd7: act_nxt[1]  = L'(ev);
          4'd8: act_nxt[2]  = L'(ev);
          default: ;
        endcase
        ej_nxt = ej_r + 4'd1;
      end

      // Advance the period position.
      ST_FIN: begin
        if (pos_inc >= {1'b0, period_eff}) begin
          pos_nxt = '0;
          gen_nxt = (gen_r >= 2'd2) ? 2'd0 : gen_r + 2'd1;
        end else begin
          pos_nxt = P'(pos_inc);
        end
      end

      // Hand the nine levels to the output register once it is free.
      ST_OUT: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          for (int k = 0; k < 3; k++) begin
            out_lv_nxt[k]     = FIELD_W'(sig_r[k]);
            out_lv_nxt[3 + k] = FIELD_W'(anti_r[k]);
            out_lv_nxt[6 + k] = FIELD_W'(act_r[k]);
          end
        end
      end

      // Four 32x32 partial products, each registered before it is added.
      ST_MUL: begin
        if (mcnt_r != MUL_LAST)
          prod_nxt = (mcnt_r[0] ? opa_r[63:32] : opa_r[31:0]) *
                     (mcnt_r[1] ? opb_r[63:32] : opb_r[31:0]);
        if (mcnt_r != 3'd0)
          acc_nxt = acc_r + (128'(prod_r) << {mslot, 5'b0});
        mcnt_nxt = mcnt_r + 3'd1;
      end

      // Restoring division, one quotient bit per cycle.
      ST_DIV: begin
        if (dcnt_r == 6'd0) begin
          dq_nxt = (dr_r >= dden_r) ? 37'd1 : 37'd0;
          dr_nxt = (dr_r >= dden_r) ? dr_r - dden_r : dr_r;
        end else begin
          dq_nxt = {dq_r[35:0], dtake};
          dr_nxt = dtake ? dshift - dden_r : dshift;
        end
        dcnt_nxt = dcnt_r + 6'd1;
      end

      default: ;
    endcase
  end

  // Control, configuration and model state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ret_r        <= ST_IDLE;
      hk_r         <= HK_SIGMA;
      vi_r         <= '0;
      ej_r         <= '0;
      mcnt_r       <= '0;
      dcnt_r       <= '0;
      restart_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      self_gain_r  <= SELF_GAIN_RST;
      cross_gain_r <= CROSS_GAIN_RST;
      decay_r      <= DECAY_RST;
      act_decay_r  <= ACT_DECAY_RST;
      period_r     <= P'(PERIOD_RST);
      pulse_ticks_r <= P'(PULSE_RST);
      pulse_amt_r  <= PULSE_AMT_RST;
      init_a_r     <= INIT_A_RST;
      for (int k = 0; k < 3; k++) begin
        sig_r[k]  <= '0;
        anti_r[k] <= '0;
        act_r[k]  <= '0;
      end
      sig_r[0] <= (64'(INIT_A_RST) > LMAX) ? L'(LMAX) : L'(INIT_A_RST);
      pos_r    <= '0;
      gen_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      hk_r        <= hk_nxt;
      vi_r        <= vi_nxt;
      ej_r        <= ej_nxt;
      mcnt_r      <= mcnt_nxt;
      dcnt_r      <= dcnt_nxt;
      restart_r   <= restart_nxt;
      out_valid_r <= out_valid_nxt;
      for (int k = 0; k < 3; k++) begin
        sig_r[k]  <= sig_nxt[k];
        anti_r[k] <= anti_nxt[k];
        act_r[k]  <= act_nxt[k];
      end
      pos_r <= pos_nxt;
      gen_r <= gen_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_SELF_GAIN:       self_gain_r   <= cfg_wdata[GAIN_W-1:0];
          REG_CROSS_GAIN:      cross_gain_r  <= cfg_wdata[GAIN_W-1:0];
          REG_DECAY_RATE:      decay_r       <= cfg_wdata[GAIN_W-1:0];
          REG_ACTIVATOR_DECAY: act_decay_r   <= cfg_wdata[GAIN_W-1:0];
          REG_PERIOD_TICKS:    period_r      <= P'(cfg_wdata[CFG_PERIOD_W-1:0]);
          REG_PULSE_TICKS:     pulse_ticks_r <= P'(cfg_wdata[CFG_PERIOD_W-1:0]);
          REG_PULSE_AMOUNT:    pulse_amt_r   <= cfg_wdata[GAIN_W-1:0];
          REG_INITIAL_A:       init_a_r      <= cfg_wdata[INIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Arithmetic and output payload registers.
  always_ff @(posedge clk) begin
    opa_r  <= opa_nxt;
    opb_r  <= opb_nxt;
    sh_r   <= sh_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    dr_r   <= dr_nxt;
    dden_r <= dden_nxt;
    dq_r   <= dq_nxt;
    fs_r   <= fs_nxt;
    fa_r   <= fa_nxt;
    ga_r   <= ga_nxt;
    kdec_r <= kdec_nxt;
    kact_r <= kact_nxt;
    eup_r  <= eup_nxt;
    for (int k = 0; k < 3; k++) begin
      drive_r[k] <= drive_nxt[k];
      self_r[k]  <= self_nxt[k];
    end
    for (int k = 0; k < 9; k++) out_lv_r[k] <= out_lv_nxt[k];
  end

  assign out_valid        = out_valid_r;
  assign out_level_a      = out_lv_r[0];
  assign out_level_b      = out_lv_r[1];
  assign out_level_c      = out_lv_r[2];
  assign out_anti_level_a = out_lv_r[3];
  assign out_anti_level_b = out_lv_r[4];
  assign out_anti_level_c = out_lv_r[5];
  assign out_activator_a  = out_lv_r[6];
  assign out_activator_b  = out_lv_r[7];
  assign out_activator_c  = out_lv_r[8];

`ifndef SYNTHESIS
  // An accepted request always starts the load step.
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_LOAD))
    else $error("accepted request did not enter load");

  // A new result appears only when the sequencer hands it over.
  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_OUT))
    else $error("result raised outside the hand-over step");

  // The multiplier never runs past its last partial product.
  a_mul_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (mcnt_r <= MUL_LAST))
    else $error("multiplier count overrun");

  // The divider never runs past its last quotient bit.
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (dcnt_r <= DIV_LAST))
    else $error("divider count overrun");

  // A waiting result stays valid and its first level unchanged while stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_lv_r[0])))
    else $error("stalled result changed");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import hoe_pkg::*;

  localparam int NLEV = 9;
  localparam int STALL_LIMIT = 20000;
  localparam logic [63:0] LEVEL_MAX = 64'hFFFF_FFFF_FFFF;

  typedef logic [NLEV-1:0][47:0] level_set_t;

  // Gene-circuit predictor and the store of expected level sets.
  class level_board;
    logic [63:0] regs [8];
    logic [63:0] sigma [3];
    logic [63:0] anti [3];
    logic [63:0] act [3];
    longint unsigned pos;
    int gen;
    level_set_t expected_levels [$];
    int errors;

    function new();
      regs[REG_SELF_GAIN]       = SELF_GAIN_RST;
      regs[REG_CROSS_GAIN]      = CROSS_GAIN_RST;
      regs[REG_DECAY_RATE]      = DECAY_RST;
      regs[REG_ACTIVATOR_DECAY] = ACT_DECAY_RST;
      regs[REG_PERIOD_TICKS]    = PERIOD_RST;
      regs[REG_PULSE_TICKS]     = PULSE_RST;
      regs[REG_PULSE_AMOUNT]    = PULSE_AMT_RST;
      regs[REG_INITIAL_A]       = INIT_A_RST;
      errors = 0;
      reload();
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [63:0] val);
      case (idx)
        REG_PERIOD_TICKS, REG_PULSE_TICKS: regs[idx] = val & 64'hF_FFFF;
        REG_INITIAL_A: regs[idx] = val & LEVEL_MAX;
        default: regs[idx] = val & 64'hFFFF_FFFF;
      endcase
    endfunction

    function void reload();
      for (int i = 0; i < 3; i++) begin
        sigma[i] = 0;
        anti[i] = 0;
        act[i] = 0;
      end
      sigma[0] = regs[REG_INITIAL_A];
      pos = 0;
      gen = 0;
    endfunction

    function void next_generation();
      pos = 0;
      gen = (gen >= 2) ? 0 : gen + 1;
    endfunction

    // Truncated product shifted right, saturating at 64 bits.
    function logic [63:0] mul_sh(logic [63:0] a, logic [63:0] b, int s);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = p >> s;
      if (p[127:64] != 0) return '1;
      return p[63:0];
    endfunction

    function logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
    endfunction

    function logic [63:0] frac_quot(logic [63:0] num, logic [63:0] den);
      logic [127:0] q;
      q = ({64'd0, num} << 36) / {64'd0, den};
      return q[63:0];
    endfunction

    // Hill saturation: rising x^2/(0.25+x^2) and falling 0.25/(0.25+x^2).
    function void hill(logic [63:0] x, output logic [63:0] up, output logic [63:0] dn);
      logic [63:0] x2, den;
      x2 = mul_sh(x, x, 36);
      den = sat_sum(x2, QUARTER);
      if (x2 > den) x2 = den;
      up = frac_quot(x2, den);
      dn = frac_quot(QUARTER, den);
    endfunction

    function logic [63:0] euler(logic [63:0] prev, logic [63:0] gain, logic [63:0] rdt);
      logic [63:0] up, down, v;
      up = mul_sh(gain, DT_Q32, 32);
      down = mul_sh(prev, rdt, 56);
      if (up >= down) v = sat_sum(prev, up - down);
      else v = (prev > down - up) ? prev - (down - up) : 0;
      if (v > LEVEL_MAX) v = LEVEL_MAX;
      if (v < CUT_LIMIT) v = 0;
      return v;
    endfunction

    // One accepted tick: advance the model and queue the expected levels.
    function void note_request(bit restart);
      longint unsigned period;
      logic [63:0] fs [3], gs [3], fa [3], ga [3], drive [3], selfd [3];
      logic [63:0] junk, kdec, kact, v;
      logic [63:0] ns [3], na [3], nc [3];
      level_set_t e;
      period = (regs[REG_PERIOD_TICKS] == 0) ? 1 : regs[REG_PERIOD_TICKS];
      if (restart) reload();
      if (pos >= period) next_generation();
      // Activator pulse near the end of the period.
      if (pos + regs[REG_PULSE_TICKS] > period) begin
        v = sat_sum(act[gen], regs[REG_PULSE_AMOUNT]);
        act[gen] = (v > LEVEL_MAX) ? LEVEL_MAX : v;
      end
      for (int i = 0; i < 3; i++) begin
        hill(sigma[i], fs[i], gs[i]);
        hill(anti[i], junk, ga[i]);
        hill(act[i], fa[i], junk);
        drive[i] = mul_sh(regs[REG_CROSS_GAIN],
                          mul_sh(mul_sh(fs[i], fa[i], 36), ga[i], 36), 24);
        selfd[i] = mul_sh(regs[REG_SELF_GAIN], mul_sh(fs[i], ga[i], 36), 24);
      end
      kdec = regs[REG_DECAY_RATE] * DT_Q32;
      kact = regs[REG_ACTIVATOR_DECAY] * DT_Q32;
      for (int i = 0; i < 3; i++) begin
        ns[i] = euler(sigma[i], sat_sum(selfd[i], drive[(i + 2) % 3]), kdec);
        na[i] = euler(anti[i], drive[i], kdec);
        nc[i] = euler(act[i], 0, kact);
      end
      for (int i = 0; i < 3; i++) begin
        sigma[i] = ns[i];
        anti[i] = na[i];
        act[i] = nc[i];
        e[i] = ns[i][47:0];
        e[3 + i] = na[i][47:0];
        e[6 + i] = nc[i][47:0];
      end
      pos++;
      if (pos >= period) next_generation();
      expected_levels.push_back(e);
    endfunction

    task report_mismatch(string what);
      $display("ERROR %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(level_set_t got);
      level_set_t e;
      string names [NLEV] = '{"level_a", "level_b", "level_c", "anti_level_a",
        "anti_level_b", "anti_level_c", "activator_a", "activator_b", "activator_c"};
      if (expected_levels.size() == 0) begin
        report_mismatch("result with no request pending");
        return;
      end
      e = expected_levels.pop_front();
      for (int i = 0; i < NLEV; i++)
        if (got[i] !== e[i])
          report_mismatch($sformatf("%s got %h expected %h", names[i], got[i], e[i]));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_restart = 0;
  logic out_stall = 0;
  logic in_stall, out_valid;
  level_set_t got;
  int idle_pct = 20;
  int quiet_cycles = 0;
  level_board board = new();

  hill_ode_euler_stepper dut (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata,
    .in_valid, .in_stall, .in_restart, .out_valid, .out_stall,
    .out_level_a(got[0]), .out_level_b(got[1]), .out_level_c(got[2]),
    .out_anti_level_a(got[3]), .out_anti_level_b(got[4]), .out_anti_level_c(got[5]),
    .out_activator_a(got[6]), .out_activator_b(got[7]), .out_activator_c(got[8])
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Result side: check accepted levels and stall at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(got);
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_tick(bit restart);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
    board.note_request(restart);
  endtask

  // Registers change only once every pending request has returned.
  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [63:0] val);
    in_valid <= 0;
    while (board.expected_levels.size() != 0) @(posedge clk);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 0;
    board.set_reg(idx, val);
  endtask

  function automatic logic [63:0] rand_gain();
    case ($urandom_range(5))
      0: return 0;
      1: return 64'hFFFF_FFFF;
      2: return $urandom_range(32'h0800_0000);
      default: return $urandom_range(32'h0400_0000);
    endcase
  endfunction

  initial begin
    int period, sent, n;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Reset settings, with and without restart.
    send_tick(1);
    send_tick(0);
    send_tick(0);
    // Short period so pulses land and generations cycle.
    write_reg(REG_PERIOD_TICKS, 4);
    write_reg(REG_PULSE_TICKS, 2);
    write_reg(REG_PULSE_AMOUNT, 64'hFFFF_FFFF);
    write_reg(REG_CROSS_GAIN, 64'h1000_0000);
    repeat (8) send_tick(0);
    // Period shrinks below the current position, then a zero period.
    write_reg(REG_PERIOD_TICKS, 1);
    send_tick(0);
    write_reg(REG_PERIOD_TICKS, 0);
    write_reg(REG_PULSE_TICKS, 64'hF_FFFF);
    send_tick(0);
    send_tick(0);
    // Largest initial level and self gain; decays at both extremes.
    write_reg(REG_INITIAL_A, LEVEL_MAX);
    write_reg(REG_SELF_GAIN, 64'hFFFF_FFFF);
    write_reg(REG_DECAY_RATE, 0);
    write_reg(REG_ACTIVATOR_DECAY, 0);
    send_tick(1);
    send_tick(0);
    write_reg(REG_DECAY_RATE, 64'hFFFF_FFFF);
    write_reg(REG_ACTIVATOR_DECAY, 64'hFFFF_FFFF);
    send_tick(0);
    write_reg(REG_PERIOD_TICKS, 64'hF_FFFF);
    write_reg(REG_PULSE_TICKS, 0);
    write_reg(REG_INITIAL_A, 0);
    write_reg(REG_SELF_GAIN, 0);
    write_reg(REG_CROSS_GAIN, 0);
    write_reg(REG_PULSE_AMOUNT, 0);
    send_tick(1);
    send_tick(0);

    // Random phases, each with fresh settings.
    sent = 0;
    while (sent < 730) begin
      if ($urandom_range(7) == 0) period = $urandom_range(20'hF_FFFF);
      else period = $urandom_range(1, 40);
      write_reg(REG_PERIOD_TICKS, period);
      write_reg(REG_PULSE_TICKS, ($urandom_range(7) == 0) ?
                $urandom_range(20'hF_FFFF) : $urandom_range(period + 3));
      write_reg(REG_PULSE_AMOUNT, ($urandom_range(3) == 0) ?
                $urandom : $urandom_range(32'h2000_0000));
      write_reg(REG_SELF_GAIN, rand_gain());
      write_reg(REG_CROSS_GAIN, rand_gain());
      write_reg(REG_DECAY_RATE, rand_gain());
      write_reg(REG_ACTIVATOR_DECAY, rand_gain());
      if ($urandom_range(3) == 0)
        write_reg(REG_INITIAL_A, {$urandom, $urandom} & LEVEL_MAX);
      else
        write_reg(REG_INITIAL_A, $urandom_range(32'hFFFF_FFFF) << $urandom_range(4));
      idle_pct = (sent >= 300 && sent < 400) ? 0 : 20;
      n = $urandom_range(30, 60);
      for (int i = 0; i < n; i++) send_tick(i == 0 || $urandom_range(29) == 0);
      sent += n;
    end
    in_valid <= 0;

    while (board.expected_levels.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
    if (board.errors == 0 && board.expected_levels.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
